// ===== hdl/htw_pkg.sv =====
`default_nettype none

package htw_pkg;

    // entry pointers are 7 bits wide, all ones marks the end of a list
    localparam int PTR_W = 7;
    localparam logic [PTR_W-1:0] NIL = 7'd127;
    localparam logic [2*PTR_W-1:0] EMPTY_ENDS = {NIL, NIL};

    typedef logic [PTR_W-1:0] t_ptr;
    typedef logic [2*PTR_W-1:0] t_ends;

    // classified request kinds
    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_NOW  = 2'd1,
        OP_TICK = 2'd2
    } t_op;

    // result kinds
    typedef enum logic [1:0] {
        KIND_EXPIRED = 2'd0,
        KIND_NOW     = 2'd1,
        KIND_REJECT  = 2'd2
    } t_kind;

    typedef struct packed {
        t_op         op;
        logic [31:0] handle;
        logic [31:0] session;
        logic [31:0] delay;
    } t_item;

    // queue head seen by the engine
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

    // engine controls toward the front
    typedef struct packed {
        logic pop;
        logic hold;
    } t_qctl;

    typedef struct packed {
        logic [31:0] expire;
        logic [31:0] handle;
        logic [31:0] session;
    } t_entry;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] handle;
        logic [31:0] session;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/htw_if.sv =====
`default_nettype none

// request channel
interface htw_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] source_handle;
    logic [31:0] session_id;
    logic [31:0] delay_ms;

    modport source (output valid, func, source_handle, session_id, delay_ms, input ready);
    modport sink   (input valid, func, source_handle, session_id, delay_ms, output ready);
endinterface

// result channel
interface htw_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] expired_handle;
    logic [31:0] expired_session;
    logic        last_flag;

    modport source (output valid, kind, expired_handle, expired_session, last_flag,
                    input ready);
    modport sink   (input valid, kind, expired_handle, expired_session, last_flag,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/htw_ram.sv =====
`default_nettype none

module htw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/htw_front.sv =====
`default_nettype none

module htw_front
    import htw_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    htw_in_if.sink      i_in,
    input  wire t_qctl  i_ctl,
    output t_qhead      o_head
);

    t_item      r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    t_item      w_item;
    logic       w_push;

    // classify the incoming request
    always_comb begin
        w_item.handle  = i_in.source_handle;
        w_item.session = i_in.session_id;
        w_item.delay   = i_in.delay_ms;
        if (i_in.func) begin
            w_item.op = OP_TICK;
        end else if (i_in.delay_ms == 32'd0) begin
            w_item.op = OP_NOW;
        end else begin
            w_item.op = OP_ADD;
        end
    end

    assign i_in.ready = (r_cnt != 2'd2) && !i_ctl.hold;
    assign w_push     = i_in.valid && i_in.ready;

    // two-entry queue toward the engine
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_item;
        end
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (i_ctl.pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_ctl.pop};
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_mem[r_rd];

endmodule

`default_nettype wire

// ===== hdl/htw_engine.sv =====
`default_nettype none

module htw_engine
    import htw_pkg::*;
#(
    parameter int NEAR_BITS  = 8,
    parameter int LEVEL_BITS = 8,
    parameter int LEVELS     = 3,
    parameter int ENTRIES    = 64
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_qhead i_head,
    output t_qctl       o_ctl,
    htw_out_if.source   o_out
);

    localparam int NS    = 1 << NEAR_BITS;
    localparam int LS    = 1 << LEVEL_BITS;
    localparam int LD    = LEVELS * LS;
    localparam int LAW   = $clog2(LD);
    localparam int EW    = $clog2(ENTRIES);
    localparam int GW    = $clog2(ENTRIES + 1);
    localparam int CLR_A = (LD > NS) ? LD : NS;
    localparam int CLR_N = (CLR_A > ENTRIES) ? CLR_A : ENTRIES;
    localparam int CW    = $clog2(CLR_N);

    typedef enum logic [12:0] {
        S_CLR    = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_ADD    = 13'b0000000000100,
        S_FREE   = 13'b0000000001000,
        S_PRD    = 13'b0000000010000,
        S_PWR    = 13'b0000000100000,
        S_WHEAD  = 13'b0000001000000,
        S_WCLR   = 13'b0000010000000,
        S_WTEST  = 13'b0000100000000,
        S_WDATA  = 13'b0001000000000,
        S_EMIT   = 13'b0010000000000,
        S_ADV    = 13'b0100000000000,
        S_FINISH = 13'b1000000000000
    } t_state;

    typedef struct packed {
        logic                 near;
        logic [NEAR_BITS-1:0] nidx;
        logic [LAW-1:0]       laddr;
    } t_place;

    typedef struct packed {
        logic           casc;
        logic [LAW-1:0] addr;
    } t_adv;

    // bucket for an expiry time relative to the current time
    function automatic t_place f_place(input logic [31:0] x, input logic [31:0] t);
        t_place      p;
        logic [31:0] low;
        logic [31:0] nm;
        logic [31:0] idx;
        int          lvl;
        int          span;
        int          sh;
        logic        stop;
        nm     = 32'(NS - 1);
        p.near = ((x | nm) == (t | nm));
        p.nidx = x[NEAR_BITS-1:0];
        lvl    = 0;
        stop   = 1'b0;
        for (int i = 0; i < LEVELS - 1; i++) begin
            if (!stop) begin
                span = NEAR_BITS + (i + 1) * LEVEL_BITS;
                if (span >= 32) begin
                    stop = 1'b1;
                end else begin
                    low = 32'((64'd1 << span) - 64'd1);
                    if ((x | low) == (t | low)) begin
                        stop = 1'b1;
                    end else begin
                        lvl = i + 1;
                    end
                end
            end
        end
        sh      = NEAR_BITS + lvl * LEVEL_BITS;
        idx     = (sh < 32) ? ((x >> sh) & 32'(LS - 1)) : 32'd0;
        p.laddr = LAW'((32'(lvl) << LEVEL_BITS) + idx);
        return p;
    endfunction

    // level bucket to cascade after time steps to ct
    function automatic t_adv f_adv(input logic [31:0] ct);
        t_adv        a;
        logic [31:0] low;
        logic [31:0] idx;
        int          sh;
        logic        done;
        a.casc = 1'b0;
        a.addr = '0;
        done   = 1'b0;
        for (int i = 0; i < LEVELS; i++) begin
            if (!done) begin
                sh  = NEAR_BITS + i * LEVEL_BITS;
                low = (sh >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << sh) - 64'd1);
                if ((ct & low) != 32'd0) begin
                    done = 1'b1;
                end else begin
                    idx = (sh < 32) ? ((ct >> sh) & 32'(LS - 1)) : 32'd0;
                    if (idx != 32'd0) begin
                        a.casc = 1'b1;
                        a.addr = LAW'((32'(i) << LEVEL_BITS) + idx);
                        done   = 1'b1;
                    end
                end
            end
        end
        if (!done) begin
            a.casc = 1'b1;
            a.addr = LAW'(32'(LEVELS - 1) << LEVEL_BITS);
        end
        return a;
    endfunction

    t_state          r_state, n_state;
    logic [31:0]     r_time, n_time;
    t_ptr            r_free_head, n_free_head;
    logic [CW-1:0]   r_clr, n_clr;
    t_item           r_item, n_item;
    t_ptr            r_pe, n_pe;
    logic [31:0]     r_px, n_px;
    logic            r_in_casc, n_in_casc;
    logic            r_mode_casc, n_mode_casc;
    logic            r_phase, n_phase;
    logic [LAW-1:0]  r_caddr, n_caddr;
    t_ptr            r_n, n_n;
    t_ptr            r_nx, n_nx;
    logic [GW-1:0]   r_guard, n_guard;
    logic [31:0]     r_dh, n_dh;
    logic [31:0]     r_ds, n_ds;
    logic            r_pend_valid, n_pend_valid;
    t_result         r_pend, n_pend;
    logic            r_out_valid, n_out_valid;
    t_result         r_out, n_out;
    logic            r_out_last, n_out_last;

    logic                 near_we;
    logic [NEAR_BITS-1:0] near_waddr;
    t_ends                near_wdata;
    logic [NEAR_BITS-1:0] near_raddr;
    t_ends                near_rdata;
    logic                 level_we;
    logic [LAW-1:0]       level_waddr;
    t_ends                level_wdata;
    logic [LAW-1:0]       level_raddr;
    t_ends                level_rdata;
    logic                 link_we;
    logic [EW-1:0]        link_waddr;
    t_ptr                 link_wdata;
    logic [EW-1:0]        link_raddr;
    t_ptr                 link_rdata;
    logic                 data_we;
    logic [EW-1:0]        data_waddr;
    t_entry               data_wdata;
    logic [EW-1:0]        data_raddr;
    t_entry               data_rdata;

    t_place      w_pl;
    t_adv        w_adv;
    logic [31:0] w_ct;
    t_ends       w_ends;
    t_ptr        w_head;
    t_ptr        w_tail;
    logic        w_out_free;

    // bucket ends, entry links and entry payload stores
    htw_ram #(.WIDTH(2 * PTR_W), .DEPTH(NS)) u_near (
        .i_clk(i_clk), .i_we(near_we), .i_waddr(near_waddr), .i_wdata(near_wdata),
        .i_raddr(near_raddr), .o_rdata(near_rdata)
    );

    htw_ram #(.WIDTH(2 * PTR_W), .DEPTH(LD)) u_level (
        .i_clk(i_clk), .i_we(level_we), .i_waddr(level_waddr), .i_wdata(level_wdata),
        .i_raddr(level_raddr), .o_rdata(level_rdata)
    );

    htw_ram #(.WIDTH(PTR_W), .DEPTH(ENTRIES)) u_link (
        .i_clk(i_clk), .i_we(link_we), .i_waddr(link_waddr), .i_wdata(link_wdata),
        .i_raddr(link_raddr), .o_rdata(link_rdata)
    );

    htw_ram #(.WIDTH($bits(t_entry)), .DEPTH(ENTRIES)) u_data (
        .i_clk(i_clk), .i_we(data_we), .i_waddr(data_waddr), .i_wdata(data_wdata),
        .i_raddr(data_raddr), .o_rdata(data_rdata)
    );

    assign w_pl       = f_place(r_px, r_time);
    assign w_ct       = r_time + 32'd1;
    assign w_adv      = f_adv(w_ct);
    assign w_out_free = !r_out_valid || o_out.ready;

    // bucket ends as read by placement or by a walk
    always_comb begin
        if (r_state == S_PWR) begin
            w_ends = w_pl.near ? near_rdata : level_rdata;
        end else begin
            w_ends = r_mode_casc ? level_rdata : near_rdata;
        end
    end
    assign w_head = w_ends[2*PTR_W-1:PTR_W];
    assign w_tail = w_ends[PTR_W-1:0];

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_time       = r_time;
        n_free_head  = r_free_head;
        n_clr        = r_clr;
        n_item       = r_item;
        n_pe         = r_pe;
        n_px         = r_px;
        n_in_casc    = r_in_casc;
        n_mode_casc  = r_mode_casc;
        n_phase      = r_phase;
        n_caddr      = r_caddr;
        n_n          = r_n;
        n_nx         = r_nx;
        n_guard      = r_guard;
        n_dh         = r_dh;
        n_ds         = r_ds;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out        = r_out;
        n_out_last   = r_out_last;
        o_ctl.pop    = 1'b0;
        o_ctl.hold   = (r_state == S_CLR);

        near_we     = 1'b0;
        near_waddr  = w_pl.nidx;
        near_wdata  = EMPTY_ENDS;
        near_raddr  = r_time[NEAR_BITS-1:0];
        level_we    = 1'b0;
        level_waddr = r_caddr;
        level_wdata = EMPTY_ENDS;
        level_raddr = r_caddr;
        link_we     = 1'b0;
        link_waddr  = r_pe[EW-1:0];
        link_wdata  = NIL;
        link_raddr  = r_n[EW-1:0];
        data_we     = 1'b0;
        data_waddr  = r_free_head[EW-1:0];
        data_wdata  = {r_time + r_item.delay - 32'd1, r_item.handle, r_item.session};
        data_raddr  = r_n[EW-1:0];

        case (r_state)
            // clearing pass: empty buckets, chain the free list
            S_CLR: begin
                near_we     = (32'(r_clr) < NS);
                near_waddr  = r_clr[NEAR_BITS-1:0];
                level_we    = (32'(r_clr) < LD);
                level_waddr = r_clr[LAW-1:0];
                link_we     = (32'(r_clr) < ENTRIES);
                link_waddr  = r_clr[EW-1:0];
                link_wdata  = (32'(r_clr) == ENTRIES - 1) ? NIL : PTR_W'(32'(r_clr) + 32'd1);
                if (32'(r_clr) == CLR_N - 1) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_head.valid) begin
                    o_ctl.pop = 1'b1;
                    n_item    = i_head.item;
                    case (i_head.item.op)
                        OP_NOW: begin
                            n_pend       = {KIND_NOW, i_head.item.handle, i_head.item.session};
                            n_pend_valid = 1'b1;
                            n_state      = S_FINISH;
                        end
                        OP_ADD: begin
                            if (32'(r_free_head) >= ENTRIES) begin
                                n_pend       = {KIND_REJECT, i_head.item.handle,
                                                i_head.item.session};
                                n_pend_valid = 1'b1;
                                n_state      = S_FINISH;
                            end else begin
                                n_state = S_ADD;
                            end
                        end
                        OP_TICK: begin
                            n_phase     = 1'b0;
                            n_mode_casc = 1'b0;
                            n_state     = S_WHEAD;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            // take the free head and store the payload
            S_ADD: begin
                data_we    = 1'b1;
                link_raddr = r_free_head[EW-1:0];
                n_pe       = r_free_head;
                n_px       = r_time + r_item.delay - 32'd1;
                n_in_casc  = 1'b0;
                n_state    = S_FREE;
            end
            S_FREE: begin
                n_free_head = link_rdata;
                n_state     = S_PRD;
            end
            // placement: read bucket ends, terminate the entry link
            S_PRD: begin
                near_raddr  = w_pl.nidx;
                level_raddr = w_pl.laddr;
                link_we     = 1'b1;
                link_waddr  = r_pe[EW-1:0];
                link_wdata  = NIL;
                n_state     = S_PWR;
            end
            // placement: append at the tail
            S_PWR: begin
                near_we     = w_pl.near;
                near_waddr  = w_pl.nidx;
                level_we    = !w_pl.near;
                level_waddr = w_pl.laddr;
                if (32'(w_head) >= ENTRIES) begin
                    near_wdata  = {r_pe, r_pe};
                    level_wdata = {r_pe, r_pe};
                end else begin
                    near_wdata  = {w_head, r_pe};
                    level_wdata = {w_head, r_pe};
                    link_we     = (32'(w_tail) < ENTRIES);
                end
                link_waddr = w_tail[EW-1:0];
                link_wdata = r_pe;
                if (r_in_casc) begin
                    n_n     = r_nx;
                    n_guard = r_guard + 1'b1;
                    n_state = S_WTEST;
                end else begin
                    n_state = S_IDLE;
                end
            end
            // walk: read the bucket to drain
            S_WHEAD: begin
                near_raddr  = r_time[NEAR_BITS-1:0];
                level_raddr = r_caddr;
                n_state     = S_WCLR;
            end
            S_WCLR: begin
                near_we     = !r_mode_casc;
                near_waddr  = r_time[NEAR_BITS-1:0];
                level_we    = r_mode_casc;
                level_waddr = r_caddr;
                n_n         = w_head;
                n_guard     = '0;
                n_state     = S_WTEST;
            end
            S_WTEST: begin
                link_raddr = r_n[EW-1:0];
                data_raddr = r_n[EW-1:0];
                if ((32'(r_n) < ENTRIES) && (32'(r_guard) < ENTRIES)) begin
                    n_state = S_WDATA;
                end else if (r_mode_casc) begin
                    n_mode_casc = 1'b0;
                    n_phase     = 1'b1;
                    n_state     = S_WHEAD;
                end else if (!r_phase) begin
                    n_state = S_ADV;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_WDATA: begin
                n_nx = link_rdata;
                n_px = data_rdata.expire;
                n_dh = data_rdata.handle;
                n_ds = data_rdata.session;
                if (r_mode_casc) begin
                    n_pe      = r_n;
                    n_in_casc = 1'b1;
                    n_state   = S_PRD;
                end else begin
                    n_state = S_EMIT;
                end
            end
            // report an expired entry and return it to the free list
            S_EMIT: begin
                if (!r_pend_valid || w_out_free) begin
                    if (r_pend_valid) begin
                        n_out       = r_pend;
                        n_out_last  = 1'b0;
                        n_out_valid = 1'b1;
                    end
                    n_pend       = {KIND_EXPIRED, r_dh, r_ds};
                    n_pend_valid = 1'b1;
                    link_we      = 1'b1;
                    link_waddr   = r_n[EW-1:0];
                    link_wdata   = r_free_head;
                    n_free_head  = r_n;
                    n_n          = r_nx;
                    n_guard      = r_guard + 1'b1;
                    n_state      = S_WTEST;
                end
            end
            S_ADV: begin
                n_time  = w_ct;
                n_state = S_WHEAD;
                if (w_adv.casc) begin
                    n_caddr     = w_adv.addr;
                    n_mode_casc = 1'b1;
                end else begin
                    n_phase = 1'b1;
                end
            end
            // last result of the request carries the last flag
            S_FINISH: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    n_out        = r_pend;
                    n_out_last   = 1'b1;
                    n_out_valid  = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_pe    <= n_pe;
        r_px    <= n_px;
        r_caddr <= n_caddr;
        r_n     <= n_n;
        r_nx    <= n_nx;
        r_dh    <= n_dh;
        r_ds    <= n_ds;
        r_pend  <= n_pend;
        r_out   <= n_out;
        r_out_last <= n_out_last;
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_time       <= 32'd0;
            r_free_head  <= '0;
            r_clr        <= '0;
            r_in_casc    <= 1'b0;
            r_mode_casc  <= 1'b0;
            r_phase      <= 1'b0;
            r_guard      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_time       <= n_time;
            r_free_head  <= n_free_head;
            r_clr        <= n_clr;
            r_in_casc    <= n_in_casc;
            r_mode_casc  <= n_mode_casc;
            r_phase      <= n_phase;
            r_guard      <= n_guard;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.kind            = r_out.kind;
    assign o_out.expired_handle  = r_out.handle;
    assign o_out.expired_session = r_out.session;
    assign o_out.last_flag       = r_out_last;

    // free list head is an entry or the end marker
    a_free_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_free_head) < ENTRIES) || (r_free_head == NIL))
        else $error("free list head out of range");

    // walk never runs past the pool size
    a_guard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_guard) <= ENTRIES)
        else $error("walk guard overrun");

    // final transfer of a request carries the last flag
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) && r_pend_valid && w_out_free |=> r_out_valid && r_out_last)
        else $error("final result without last flag");

    // no request is taken during the clearing pass
    a_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !o_ctl.pop)
        else $error("request taken while clearing");

    // only real entries are appended to a bucket
    a_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PWR) |-> (32'(r_pe) < ENTRIES))
        else $error("append of an invalid entry");

endmodule

`default_nettype wire

// ===== hdl/hierarchical_timer_wheel.sv =====
// Hierarchical timing wheel with a bounded pool of timeouts.
// Request channel i_in: func 0 adds a timeout (source_handle, session_id,
// delay_ms), func 1 is one tick. Result channel o_out gives kind, handle,
// session and last_flag, which marks the final result of a request.
// An add with zero delay answers at once with kind 1; an add into a full
// pool answers with kind 2; an accepted add gives no result.
// A tick drains the current near slot, steps time, cascades at most one
// level bucket and drains the new near slot; results leave in bucket order.
// Requests pass a two-entry queue into a single sequencer, one at a time.
// An add passes the states S_ADD, S_FREE, S_PRD and S_PWR; a tick walks
// each expired and cascaded entry in turn, bounded by the pool size.
// The entry and bucket stores have one write and one registered read port.
// After reset a clearing pass empties all buckets and chains the free list;
// no request is taken until it ends. A stalled receiver holds the result
// register; the sequencer then waits and the queue fills.
`default_nettype none

module hierarchical_timer_wheel
    import htw_pkg::*;
#(
    parameter int NEAR_BITS  = 8,
    parameter int LEVEL_BITS = 8,
    parameter int LEVELS     = 3,
    parameter int ENTRIES    = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    htw_in_if.sink    i_in,
    htw_out_if.source o_out
);

    t_qhead w_head;
    t_qctl  w_ctl;

    // front: classify and queue requests
    htw_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (i_in),
        .i_ctl  (w_ctl),
        .o_head (w_head)
    );

    // back: wheel sequencer with its stores and result register
    htw_engine #(
        .NEAR_BITS (NEAR_BITS),
        .LEVEL_BITS(LEVEL_BITS),
        .LEVELS    (LEVELS),
        .ENTRIES   (ENTRIES)
    ) u_engine (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_head (w_head),
        .o_ctl  (w_ctl),
        .o_out  (o_out)
    );

endmodule

`default_nettype wire
